/* sv/mprm_pkg.sv */
// Package for the multichannel peak / RMS meter.
// Holds the widths, register indexes, controller states and command/status structs.
// No dependencies.
`default_nettype none
package mprm_pkg;
    localparam int MaxCh   = 8;
    localparam int ChW     = 3;
    localparam int CntW    = 4;
    localparam int SampW   = 24;
    localparam int SqW     = 64;
    localparam int MsW     = 47;
    localparam int MsAllW  = 50;
    localparam int RootW   = 25;
    localparam int FrameW  = 24;
    localparam int ClipW   = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 24;
    localparam int OutW    = 112;

    localparam logic [CfgIdxW-1:0] CFG_CHANNELS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_PUBLISH  = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_DECAY    = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_CLIP     = 2'd3;

    localparam logic [CntW-1:0]   SUMMARY_ID = 4'd8;
    localparam logic [MsW-1:0]    MS_MAX     = 47'h4000_0000_0000;
    localparam logic [FrameW-1:0] CNT24_MAX  = 24'hFF_FFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_SAMPLE, S_HOLD, S_CLOSE, S_REPORT, S_DIV, S_SQRT, S_EMIT, S_CLEAR
    } t_state;

    typedef struct packed {
        logic load_in;
        logic sample;
        logic hold;
        logic close;
        logic ch_clr;
        logic ch_inc;
        logic div_start;
        logic sqrt_start;
        logic emit;
        logic sum_sel;
        logic pub_clear;
    } t_cmd;

    typedef struct packed {
        logic eob;
        logic ch_last;
        logic pub;
        logic div_done;
        logic sqrt_done;
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

/* sv/mprm_ctrl.sv */
// Controller FSM of the meter: sequences sample update, block-end walk and reports.
// Depends on mprm_pkg.
`default_nettype none
module mprm_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  wire mprm_pkg::t_status i_status,
    output mprm_pkg::t_cmd     o_cmd
);
    mprm_pkg::t_state r_state, n_state;
    logic r_sum_mode, n_sum_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mprm_pkg::S_IDLE;
            r_sum_mode <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sum_mode <= n_sum_mode;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_sum_mode = r_sum_mode;
        case (r_state)
            mprm_pkg::S_IDLE: begin
                if (i_s_tvalid) n_state = mprm_pkg::S_SAMPLE;
            end
            mprm_pkg::S_SAMPLE: begin
                n_state = i_status.eob ? mprm_pkg::S_HOLD : mprm_pkg::S_IDLE;
            end
            mprm_pkg::S_HOLD: begin
                if (i_status.ch_last) n_state = mprm_pkg::S_CLOSE;
            end
            mprm_pkg::S_CLOSE: begin
                n_state    = mprm_pkg::S_REPORT;
                n_sum_mode = 1'b0;
            end
            mprm_pkg::S_REPORT: begin
                n_state = i_status.pub ? mprm_pkg::S_DIV : mprm_pkg::S_EMIT;
            end
            mprm_pkg::S_DIV: begin
                if (i_status.div_done) n_state = mprm_pkg::S_SQRT;
            end
            mprm_pkg::S_SQRT: begin
                if (i_status.sqrt_done) n_state = mprm_pkg::S_EMIT;
            end
            mprm_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    if (r_sum_mode) begin
                        n_state = i_status.pub ? mprm_pkg::S_CLEAR : mprm_pkg::S_IDLE;
                    end else begin
                        n_state = mprm_pkg::S_REPORT;
                        if (i_status.ch_last) n_sum_mode = 1'b1;
                    end
                end
            end
            mprm_pkg::S_CLEAR: begin
                n_state = mprm_pkg::S_IDLE;
            end
            default: n_state = mprm_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.sum_sel = r_sum_mode;
        o_s_tready    = 1'b0;
        case (r_state)
            mprm_pkg::S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.load_in = i_s_tvalid;
            end
            mprm_pkg::S_SAMPLE: begin
                o_cmd.sample = 1'b1;
                o_cmd.ch_clr = 1'b1;
            end
            mprm_pkg::S_HOLD: begin
                o_cmd.hold   = 1'b1;
                o_cmd.ch_inc = !i_status.ch_last;
                o_cmd.ch_clr = i_status.ch_last;
            end
            mprm_pkg::S_CLOSE: begin
                o_cmd.close = 1'b1;
            end
            mprm_pkg::S_REPORT: begin
                o_cmd.div_start = i_status.pub;
            end
            mprm_pkg::S_DIV: begin
                o_cmd.sqrt_start = i_status.div_done;
            end
            mprm_pkg::S_SQRT: begin
            end
            mprm_pkg::S_EMIT: begin
                o_cmd.emit   = i_status.out_free;
                o_cmd.ch_inc = i_status.out_free && !r_sum_mode && !i_status.ch_last;
            end
            mprm_pkg::S_CLEAR: begin
                o_cmd.pub_clear = 1'b1;
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* sv/mprm_dp.sv */
// Datapath of the meter: config registers, per-channel state, serial divider,
// serial square root and the output register. Depends on mprm_pkg.
`default_nettype none
module mprm_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire [mprm_pkg::SampW-1:0]             i_sample,
    input  wire [mprm_pkg::ChW-1:0]               i_channel,
    input  wire                                   i_eob,
    input  wire                                   i_cfg_valid,
    input  wire [mprm_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  wire [mprm_pkg::CfgDatW-1:0]           i_cfg_data,
    input  wire                                   i_m_tready,
    input  wire mprm_pkg::t_cmd                   i_cmd,
    output mprm_pkg::t_status                     o_status,
    output logic                                  o_m_tvalid,
    output logic [mprm_pkg::OutW-1:0]             o_m_tdata,
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast
);
    // configuration
    logic [3:0]  r_cc;
    logic [20:0] r_pf;
    logic [15:0] r_decay;
    logic [23:0] r_clip_lvl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc       <= 4'd2;
            r_pf       <= 21'd4096;
            r_decay    <= 16'd65000;
            r_clip_lvl <= 24'd8380220;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mprm_pkg::CFG_CHANNELS: r_cc       <= i_cfg_data[3:0];
                mprm_pkg::CFG_PUBLISH:  r_pf       <= i_cfg_data[20:0];
                mprm_pkg::CFG_DECAY:    r_decay    <= i_cfg_data[15:0];
                mprm_pkg::CFG_CLIP:     r_clip_lvl <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    logic [3:0] meter;
    assign meter = (r_cc == 4'd0) ? 4'd1 : ((r_cc > 4'd8) ? 4'd8 : r_cc);

    // latched input item
    logic [23:0] r_in_samp;
    logic [2:0]  r_in_ch;
    logic        r_in_eob;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_samp <= i_sample;
            r_in_ch   <= i_channel;
            r_in_eob  <= i_eob;
        end
    end

    logic [23:0] mag;
    logic [47:0] mag_sq;
    logic        in_range;
    assign mag      = r_in_samp[23] ? (~r_in_samp + 24'd1) : r_in_samp;
    assign mag_sq   = mag * mag;
    assign in_range = {1'b0, r_in_ch} < meter;

    // per-channel state and block totals
    logic [23:0] r_blk_pk [mprm_pkg::MaxCh];
    logic [23:0] r_run_pk [mprm_pkg::MaxCh];
    logic [63:0] r_sq_sum [mprm_pkg::MaxCh];
    logic [23:0] r_hold   [mprm_pkg::MaxCh];
    logic [23:0] r_frames;
    logic [23:0] r_blk_clips;
    logic [31:0] r_clip_sum;
    logic [23:0] r_hold_all, r_peak_all;
    logic [49:0] r_ms_all;
    logic [46:0] r_ms;
    logic        r_pub;
    logic [2:0]  r_ch;

    logic [39:0] hold_prod;
    logic [23:0] hold_dec, hold_new;
    logic [20:0] period;
    assign hold_prod = r_hold[r_ch] * r_decay;
    assign hold_dec  = hold_prod[39:16];
    assign hold_new  = (r_blk_pk[r_ch] > hold_dec) ? r_blk_pk[r_ch] : hold_dec;
    assign period    = (r_pf == 21'd0) ? 21'd1 : r_pf;

    // serial restoring divider, one quotient bit per cycle
    logic [63:0] r_dvd;
    logic [23:0] r_dvs;
    logic [23:0] r_rem;
    logic [6:0]  r_div_cnt;
    logic [24:0] rem_sh;
    logic        q_bit;
    assign rem_sh = {r_rem, r_dvd[63]};
    assign q_bit  = rem_sh >= {1'b0, r_dvs};

    logic [46:0] ms_clamp;
    logic [49:0] sq_in;
    assign ms_clamp = (r_dvd > {17'd0, mprm_pkg::MS_MAX}) ? mprm_pkg::MS_MAX : r_dvd[46:0];
    assign sq_in    = i_cmd.sum_sel ? r_dvd[49:0] : {3'd0, ms_clamp};

    // serial square root, two radicand bits per cycle
    logic [49:0] r_sq_src;
    logic [24:0] r_root;
    logic [25:0] r_srem;
    logic [4:0]  r_sq_cnt;
    logic [27:0] srem_sh, trial;
    assign srem_sh = {r_srem, r_sq_src[49:48]};
    assign trial   = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
            r_sq_cnt  <= '0;
        end else begin
            if (i_cmd.div_start) begin
                r_dvd     <= i_cmd.sum_sel ? {14'd0, r_ms_all} : r_sq_sum[r_ch];
                r_dvs     <= i_cmd.sum_sel ? {20'd0, meter} : r_frames;
                r_rem     <= '0;
                r_div_cnt <= 7'd64;
            end else if (r_div_cnt != 7'd0) begin
                r_rem     <= q_bit ? 24'(rem_sh - {1'b0, r_dvs}) : rem_sh[23:0];
                r_dvd     <= {r_dvd[62:0], q_bit};
                r_div_cnt <= r_div_cnt - 7'd1;
            end
            if (i_cmd.sqrt_start) begin
                r_sq_src <= sq_in;
                r_ms     <= ms_clamp;
                r_root   <= '0;
                r_srem   <= '0;
                r_sq_cnt <= 5'd25;
            end else if (r_sq_cnt != 5'd0) begin
                if (srem_sh >= trial) begin
                    r_srem <= 26'(srem_sh - trial);
                    r_root <= {r_root[23:0], 1'b1};
                end else begin
                    r_srem <= srem_sh[25:0];
                    r_root <= {r_root[23:0], 1'b0};
                end
                r_sq_src <= {r_sq_src[47:0], 2'b00};
                r_sq_cnt <= r_sq_cnt - 5'd1;
            end
        end
    end

    // meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mprm_pkg::MaxCh; i++) begin
                r_blk_pk[i] <= '0;
                r_run_pk[i] <= '0;
                r_sq_sum[i] <= '0;
                r_hold[i]   <= '0;
            end
            r_frames    <= '0;
            r_blk_clips <= '0;
            r_clip_sum  <= '0;
            r_hold_all  <= '0;
            r_peak_all  <= '0;
            r_ms_all    <= '0;
            r_pub       <= 1'b0;
            r_ch        <= '0;
        end else begin
            if (i_cmd.ch_clr) r_ch <= '0;
            else if (i_cmd.ch_inc) r_ch <= r_ch + 3'd1;

            if (i_cmd.sample && in_range) begin
                if (mag > r_blk_pk[r_in_ch]) r_blk_pk[r_in_ch] <= mag;
                r_sq_sum[r_in_ch] <= r_sq_sum[r_in_ch] + {16'd0, mag_sq};
                if (mag >= r_clip_lvl && r_blk_clips != mprm_pkg::CNT24_MAX)
                    r_blk_clips <= r_blk_clips + 24'd1;
                if (r_in_ch == 3'd0 && r_frames != mprm_pkg::CNT24_MAX)
                    r_frames <= r_frames + 24'd1;
            end

            if (i_cmd.hold) begin
                if (r_blk_pk[r_ch] > r_run_pk[r_ch]) r_run_pk[r_ch] <= r_blk_pk[r_ch];
                r_hold[r_ch] <= hold_new;
                if (hold_new > r_hold_all) r_hold_all <= hold_new;
            end

            if (i_cmd.close) begin
                for (int i = 0; i < mprm_pkg::MaxCh; i++) r_blk_pk[i] <= '0;
                r_clip_sum  <= r_clip_sum + {8'd0, r_blk_clips};
                r_blk_clips <= '0;
                r_pub       <= (r_frames >= {3'd0, period}) && (r_frames != 24'd0);
            end

            if (i_cmd.emit) begin
                if (i_cmd.sum_sel) begin
                    r_hold_all <= '0;
                    r_peak_all <= '0;
                    r_ms_all   <= '0;
                end else if (r_pub) begin
                    r_ms_all <= r_ms_all + {3'd0, r_ms};
                    if (r_run_pk[r_ch] > r_peak_all) r_peak_all <= r_run_pk[r_ch];
                end
            end

            if (i_cmd.pub_clear) begin
                for (int i = 0; i < mprm_pkg::MaxCh; i++) begin
                    r_run_pk[i] <= '0;
                    r_sq_sum[i] <= '0;
                end
                r_frames <= '0;
            end
        end
    end

    // output register
    logic [3:0]  id_out;
    logic [23:0] hold_out, pk_out, rms_out;
    assign id_out   = i_cmd.sum_sel ? mprm_pkg::SUMMARY_ID : {1'b0, r_ch};
    assign hold_out = i_cmd.sum_sel ? r_hold_all : r_hold[r_ch];
    assign pk_out   = !r_pub ? 24'd0 : (i_cmd.sum_sel ? r_peak_all : r_run_pk[r_ch]);
    assign rms_out  = r_pub ? r_root[23:0] : 24'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_m_tdata <= {4'd0, r_clip_sum, rms_out, pk_out, hold_out, id_out};
            o_m_tuser <= r_pub;
            o_m_tlast <= i_cmd.sum_sel;
        end
    end

    assign o_status.eob       = r_in_eob;
    assign o_status.ch_last   = ({1'b0, r_ch} == (meter - 4'd1));
    assign o_status.pub       = r_pub;
    assign o_status.div_done  = (r_div_cnt == 7'd0);
    assign o_status.sqrt_done = (r_sq_cnt == 5'd0);
    assign o_status.out_free  = !o_m_tvalid || i_m_tready;
endmodule
`default_nettype wire

/* sv/multichannel_peak_rms_meter.sv */
// Sequence: a sample without block end is accepted, then applied to the meter. A block end
// adds a hold step for each channel and a close step, then per report, when publishing,
// a setup step, the serial divider, the serial square root and an emit step, or else setup and emit,
// plus a clear step after a publishing summary; report stalls lengthen each emit.
// Throughput: one item in flight at a time; no new sample is taken until the last one is through.
// Reset: synchronous, active low; clears all meter state and loads register defaults.
// Top level: controller FSM plus datapath. Depends on mprm_pkg, mprm_ctrl, mprm_dp.
`default_nettype none
module multichannel_peak_rms_meter (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // input stream
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [23:0]  i_s_tdata,   // [23:0] sample
    input  wire  [2:0]   i_s_tuser,   // [2:0] channel
    input  wire          i_s_tlast,   // end of block
    // report stream
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [111:0] o_m_tdata,   // [3:0] channel_id, [27:4] hold_level,
                                      // [51:28] peak_level, [75:52] rms_level,
                                      // [107:76] clip_total, rest zero
    output logic         o_m_tuser,   // [0] published
    output logic         o_m_tlast,   // summary transaction
    // register writes
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [23:0]  i_cfg_data
);
    mprm_pkg::t_cmd    cmd;
    mprm_pkg::t_status status;

    assign o_cfg_ready = 1'b1;  // registers take a write in any cycle

    mprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mprm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_s_tdata),
        .i_channel   (i_s_tuser),
        .i_eob       (i_s_tlast),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    // summary transaction always carries the summary id
    a_last_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[3:0] == mprm_pkg::SUMMARY_ID)
        else $error("summary id mismatch");

    // unpublished reports carry zero peak and rms
    a_unpub_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[75:28] == 48'd0)
        else $error("unpublished report with nonzero levels");

    // no report right after reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");
endmodule
`default_nettype wire

/* verif/meter_checker.sv */
// Checker for the multichannel peak / RMS meter: mirrors the meter state, predicts
// the report transactions of every accepted sample and compares them in order.
// Depends on mprm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module meter_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [23:0]  i_s_tdata,
    input  wire  [2:0]   i_s_tuser,
    input  wire          i_s_tlast,
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [111:0] i_m_tdata,
    input  wire          i_m_tuser,
    input  wire          i_m_tlast,
    input  wire          i_cfg_valid,
    input  wire          i_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [23:0]  i_cfg_data,
    output int           o_errors,
    output int           o_pending
);
    typedef struct packed {
        logic [3:0]  id;
        logic [23:0] hold;
        logic        pub;
        logic [23:0] peak;
        logic [23:0] rms;
        logic [31:0] clips;
        logic        last;
    } t_report;

    t_report reports_due[$];

    logic [3:0]  n_ch_reg;
    logic [20:0] period_reg;
    logic [15:0] decay_reg;
    logic [23:0] clip_reg;
    logic [23:0] blk_pk[mprm_pkg::MaxCh];
    logic [23:0] run_pk[mprm_pkg::MaxCh];
    logic [63:0] sq_acc[mprm_pkg::MaxCh];
    logic [23:0] hold_lvl[mprm_pkg::MaxCh];
    logic [23:0] frames;
    logic [23:0] blk_clip_cnt;
    logic [31:0] clip_acc;

    assign o_pending = reports_due.size();

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    task automatic meter_sample(input logic [23:0] raw, input logic [2:0] ch,
                                input logic eob);
        int n;
        logic [23:0] mag, h, hold_all, peak_all, period;
        logic [63:0] ms, ms_all;
        logic pub;
        t_report r;
        n = (n_ch_reg == 0) ? 1 :
            (n_ch_reg > mprm_pkg::MaxCh ? mprm_pkg::MaxCh : n_ch_reg);
        if (ch < n) begin
            mag = raw[23] ? (24'h0 - raw) : raw;  // -2^23 wraps to 2^23 as unsigned
            if (raw == 24'h80_0000) mag = 24'h80_0000;
            if (mag > blk_pk[ch]) blk_pk[ch] = mag;
            sq_acc[ch] += 64'(mag) * 64'(mag);
            if (mag >= clip_reg && blk_clip_cnt != mprm_pkg::CNT24_MAX) blk_clip_cnt++;
            if (ch == 0 && frames != mprm_pkg::CNT24_MAX) frames++;
        end
        if (!eob) return;
        hold_all = 0;
        for (int c = 0; c < n; c++) begin
            if (blk_pk[c] > run_pk[c]) run_pk[c] = blk_pk[c];
            h = 24'((40'(hold_lvl[c]) * 40'(decay_reg)) >> 16);
            if (blk_pk[c] > h) h = blk_pk[c];
            hold_lvl[c] = h;
            if (h > hold_all) hold_all = h;
        end
        for (int c = 0; c < mprm_pkg::MaxCh; c++) blk_pk[c] = 0;
        clip_acc += 32'(blk_clip_cnt);
        blk_clip_cnt = 0;
        period = (period_reg == 0) ? 24'd1 : 24'(period_reg);
        pub = (frames >= period) && (frames >= 1);
        ms_all = 0;
        peak_all = 0;
        for (int c = 0; c < n; c++) begin
            r = '0;
            r.id = 4'(c);
            r.hold = hold_lvl[c];
            r.pub = pub;
            r.clips = clip_acc;
            if (pub) begin
                ms = sq_acc[c] / 64'(frames);
                if (ms > 64'(mprm_pkg::MS_MAX)) ms = 64'(mprm_pkg::MS_MAX);
                r.peak = run_pk[c];
                r.rms = 24'(int_sqrt(ms));
                ms_all += ms;
                if (run_pk[c] > peak_all) peak_all = run_pk[c];
            end
            reports_due.push_back(r);
        end
        r = '0;
        r.id = mprm_pkg::SUMMARY_ID;
        r.hold = hold_all;
        r.pub = pub;
        r.peak = peak_all;
        r.rms = pub ? 24'(int_sqrt(ms_all / 64'(n))) : 24'd0;
        r.clips = clip_acc;
        r.last = 1'b1;
        reports_due.push_back(r);
        if (pub) begin
            for (int c = 0; c < mprm_pkg::MaxCh; c++) begin
                run_pk[c] = 0;
                sq_acc[c] = 0;
            end
            frames = 0;
        end
    endtask

    task automatic compare_report();
        t_report e;
        if (reports_due.size() == 0) begin
            $error("report transaction with none expected: tdata=%h", i_m_tdata);
            o_errors++;
            return;
        end
        e = reports_due.pop_front();
        if (i_m_tdata[3:0] != e.id) begin
            $error("channel_id: expected %0d, got %0d", e.id, i_m_tdata[3:0]);
            o_errors++;
        end
        if (i_m_tdata[27:4] != e.hold) begin
            $error("hold_level: expected %0d, got %0d", e.hold, i_m_tdata[27:4]);
            o_errors++;
        end
        if (i_m_tuser != e.pub) begin
            $error("published: expected %0d, got %0d", e.pub, i_m_tuser);
            o_errors++;
        end
        if (i_m_tdata[51:28] != e.peak) begin
            $error("peak_level: expected %0d, got %0d", e.peak, i_m_tdata[51:28]);
            o_errors++;
        end
        if (i_m_tdata[75:52] != e.rms) begin
            $error("rms_level: expected %0d, got %0d", e.rms, i_m_tdata[75:52]);
            o_errors++;
        end
        if (i_m_tdata[107:76] != e.clips) begin
            $error("clip_total: expected %0d, got %0d", e.clips, i_m_tdata[107:76]);
            o_errors++;
        end
        if (i_m_tlast != e.last) begin
            $error("last: expected %0d, got %0d", e.last, i_m_tlast);
            o_errors++;
        end
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            n_ch_reg = 4'd2;
            period_reg = 21'd4096;
            decay_reg = 16'd65000;
            clip_reg = 24'd8380220;
            for (int c = 0; c < mprm_pkg::MaxCh; c++) begin
                blk_pk[c] = 0;
                run_pk[c] = 0;
                sq_acc[c] = 0;
                hold_lvl[c] = 0;
            end
            frames = 0;
            blk_clip_cnt = 0;
            clip_acc = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    mprm_pkg::CFG_CHANNELS: n_ch_reg = i_cfg_data[3:0];
                    mprm_pkg::CFG_PUBLISH:  period_reg = i_cfg_data[20:0];
                    mprm_pkg::CFG_DECAY:    decay_reg = i_cfg_data[15:0];
                    mprm_pkg::CFG_CLIP:     clip_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) meter_sample(i_s_tdata, i_s_tuser, i_s_tlast);
            if (i_m_tvalid && i_m_tready) compare_report();
        end
    end
endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench top for multichannel_peak_rms_meter: drives samples in bursts,
// writes registers between phases, stalls the report side, gives the verdict.
// Depends on mprm_pkg, the meter RTL and meter_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int IdleLimit = 20000;
    localparam int LongStall = 600;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic [23:0]  s_data = '0;
    logic [2:0]   s_user = '0;
    logic         s_last = 1'b0;
    logic         m_ready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    wire          s_ready, m_valid, m_user, m_last, cfg_ready;
    wire  [111:0] m_data;
    int           errors, pending;
    int           idle_cycles = 0;
    bit           hold_req = 1'b0;   // asks the receiver for one long stall

    always #6 i_clk = ~i_clk;

    multichannel_peak_rms_meter uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .i_s_tlast(s_last),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data),
        .o_m_tuser(m_user), .o_m_tlast(m_last),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    meter_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .i_s_tlast(s_last),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .i_m_tuser(m_user), .i_m_tlast(m_last),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    // Receiver: its own stall pattern, modes changing every so often.
    // A rising hold_req starts a long stall counted here, while the sender
    // keeps offering samples, so the meter backs up into its input.
    initial begin
        int mode, left, stall;
        bit req_seen;
        mode = 0;
        left = 0;
        stall = 0;
        req_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !req_seen) stall = LongStall;
            req_seen = hold_req;
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 200);
            end
            left--;
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end
            else if (mode == 0) m_ready <= 1'b1;                      // no stalls
            else if (mode == 1) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 3) == 0);              // heavy stall
        end
    end

    // Watchdog: cycles with no transaction anywhere.
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // Quiesce: all reports back, then a margin for any block-end walk in flight.
    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
    endtask

    // One sample transaction; valid stays high between back-to-back sends.
    task automatic send(input logic [23:0] smp, input logic [2:0] ch, input logic eob);
        s_valid <= 1'b1;
        s_data <= smp;
        s_user <= ch;
        s_last <= eob;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'h80_0000;
            1: return 24'h7F_FFFF;
            2: return 24'(32'($urandom_range(0, 64)) - 32);
            default: return 24'($urandom);
        endcase
    endfunction

    // One interleaved block of frames; occasionally an out-of-range channel
    // or a ragged ordering.
    task automatic send_block(input int n, input int nframes, inout int sent);
        int burst;
        burst = $urandom_range(1, 12);
        for (int f = 0; f < nframes; f++) begin
            for (int c = 0; c < n; c++) begin
                logic [2:0] ch;
                ch = ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'(c);
                send(rand_sample(), ch, (f == nframes - 1) && (c == n - 1));
                sent++;
                if (--burst == 0) begin
                    gap();
                    burst = $urandom_range(1, 12);
                end
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int n;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, extremes of the sample, clip at full scale,
        // out-of-range channel carrying the block end.
        send(24'h80_0000, 3'd0, 1'b0);
        send(24'h7F_FFFF, 3'd1, 1'b0);
        send(24'h00_0000, 3'd0, 1'b0);
        send(24'hFF_FFFF, 3'd1, 1'b1);
        send(24'h12_3456, 3'd7, 1'b1);
        s_valid <= 1'b0;
        drain();
        // Publish every frame, zero decay, clip level zero, 8 channels.
        write_reg(mprm_pkg::CFG_CHANNELS, 24'd8);
        write_reg(mprm_pkg::CFG_PUBLISH, 24'd1);
        write_reg(mprm_pkg::CFG_DECAY, 24'd0);
        write_reg(mprm_pkg::CFG_CLIP, 24'd0);
        for (int c = 0; c < 8; c++) send(c[0] ? 24'h80_0000 : 24'h7F_FFFF, 3'(c), c == 7);
        send(24'h00_0010, 3'd3, 1'b1);   // block end with no frame: no publish
        s_valid <= 1'b0;
        drain();
        // Out-of-range register values: 0 and 15 channels, period 0, top clip.
        write_reg(mprm_pkg::CFG_CHANNELS, 24'd0);
        write_reg(mprm_pkg::CFG_PUBLISH, 24'd0);
        write_reg(mprm_pkg::CFG_DECAY, 24'd65535);
        write_reg(mprm_pkg::CFG_CLIP, 24'd8388608);
        send(24'h80_0000, 3'd0, 1'b0);
        send(24'h40_0000, 3'd1, 1'b1);
        s_valid <= 1'b0;
        drain();
        write_reg(mprm_pkg::CFG_CHANNELS, 24'd15);
        write_reg(mprm_pkg::CFG_PUBLISH, 24'h1F_FFFF);
        write_reg(mprm_pkg::CFG_CLIP, 24'hFF_FFFF);
        for (int c = 0; c < 8; c++) send(24'($urandom), 3'(c), c == 7);
        s_valid <= 1'b0;
        drain();

        // Random phases over several register settings.
        while (sent < 410) begin
            n = $urandom_range(1, 8);
            write_reg(mprm_pkg::CFG_CHANNELS, 24'(n));
            write_reg(mprm_pkg::CFG_PUBLISH, 24'($urandom_range(1, 4)));
            write_reg(mprm_pkg::CFG_DECAY, 24'($urandom_range(0, 65535)));
            write_reg(mprm_pkg::CFG_CLIP, 24'($urandom_range(8000000, 8388608)));
            for (int b = 0; b < 4; b++) begin
                hold_req = (b == 2 && sent < 100);
                send_block(n, $urandom_range(1, 3), sent);
            end
            hold_req = 1'b0;
            drain();
        end

        drain();
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
